### rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search core.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

   // Field widths fixed by the interface
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   // Search bounds: lower bound and (upper bound + 1), both up to the table depth
   localparam int BOUND_W = 12;

   // Item mode codes
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   // Request payload
   typedef struct packed {
      logic                      mode;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [VALUE_W-1:0] item_value;
   } stbs_req_type;

   // Response payload
   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_position;
   } stbs_rsp_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE,
      ST_FINISH
   } stbs_state_type;

   // Controller to datapath
   typedef struct packed {
      logic write_entry;
      logic start_search;
      logic issue_read;
      logic mark_hit;
      logic narrow;
      logic load_rsp;
   } stbs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic active;
      logic equal;
      logic less;
   } stbs_sts_type;

endpackage

`default_nettype wire

### rtl/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table loads and binary searches; owns the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_mode,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire stbs_pkg::stbs_sts_type sts,
   output stbs_pkg::stbs_cmd_type     cmd
);
   import stbs_pkg::*;

   stbs_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_mode == MODE_SEARCH) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sts.active ? ST_COMPARE : ST_FINISH;
         end
         ST_COMPARE: begin
            state_in = sts.equal ? ST_FINISH : ST_CHECK;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.write_entry  = req_valid && req_mode == MODE_LOAD;
            cmd.start_search = req_valid && req_mode == MODE_SEARCH;
         end
         ST_CHECK: begin
            cmd.issue_read = sts.active;
         end
         ST_COMPARE: begin
            cmd.mark_hit = sts.equal;
            cmd.narrow   = !sts.equal;
         end
         ST_FINISH: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Response valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/stbs_dpath.sv
// ----------------------------------------------------------------------------
// stbs_dpath
// Table memory, entry count register, search bounds, probe compare and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_dpath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stbs_pkg::stbs_req_type        req_data,
   input  wire logic                          csr_write,
   input  wire logic [stbs_pkg::COUNT_W-1:0]  csr_data,
   input  wire stbs_pkg::stbs_cmd_type        cmd,
   output stbs_pkg::stbs_sts_type             sts,
   output stbs_pkg::stbs_rsp_type             rsp_data
);
   import stbs_pkg::*;

   localparam int          ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

   logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]        count_ff;
   logic [BOUND_W-1:0]        lo_ff, lo_in;
   logic [BOUND_W-1:0]        hip1_ff, hip1_in;
   logic [BOUND_W-1:0]        mid_ff, mid_in;
   logic signed [VALUE_W-1:0] target_ff;
   logic signed [VALUE_W-1:0] rdata_ff;
   logic                      hit_ff;
   logic [INDEX_W-1:0]        pos_ff;
   stbs_rsp_type              rsp_ff;

   logic [16:0]               count_wide, eff_count;
   logic [BOUND_W:0]          mid_sum;
   logic [ADDR_W+BOUND_W-1:0] raddr_wide;
   logic [ADDR_W+INDEX_W-1:0] waddr_wide;
   logic [ADDR_W-1:0]         raddr, waddr;
   logic                      in_range;

   // Entry count saturated at the table depth
   assign count_wide = 17'(count_ff);
   assign eff_count  = (count_wide > DEPTH_V) ? DEPTH_V : count_wide;

   // Probe position: floor((lo + hi) / 2) with hi = hip1 - 1
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hip1_ff} - {{BOUND_W{1'b0}}, 1'b1};
   assign mid_in     = mid_sum[BOUND_W:1];
   assign raddr_wide = {{ADDR_W{1'b0}}, mid_in};
   assign raddr      = raddr_wide[ADDR_W-1:0];

   // Load address and range check
   assign waddr_wide = {{ADDR_W{1'b0}}, req_data.entry_index};
   assign waddr      = waddr_wide[ADDR_W-1:0];
   assign in_range   = 17'(req_data.entry_index) < DEPTH_V;

   // Status to the controller
   assign sts.active = lo_ff < hip1_ff;
   assign sts.equal  = rdata_ff == target_ff;
   assign sts.less   = target_ff < rdata_ff;

   // Bound updates
   always_comb begin
      lo_in   = lo_ff;
      hip1_in = hip1_ff;
      if (cmd.start_search) begin
         lo_in   = '0;
         hip1_in = eff_count[BOUND_W-1:0];
      end else if (cmd.narrow) begin
         if (sts.less) hip1_in = mid_ff;
         else          lo_in   = mid_ff + {{(BOUND_W-1){1'b0}}, 1'b1};
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write_entry && in_range) table_mem[waddr] <= req_data.item_value;
      if (cmd.issue_read)              rdata_ff <= table_mem[raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lo_ff    <= '0;
         hip1_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (csr_write) count_ff <= csr_data;
         lo_ff   <= lo_in;
         hip1_ff <= hip1_in;
         if (cmd.start_search)  hit_ff <= 1'b0;
         else if (cmd.mark_hit) hit_ff <= 1'b1;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.start_search) target_ff <= req_data.item_value;
      if (cmd.issue_read)   mid_ff    <= mid_in;
      if (cmd.mark_hit)     pos_ff    <= mid_ff[INDEX_W-1:0];
      if (cmd.load_rsp) begin
         rsp_ff.found          <= hit_ff;
         rsp_ff.match_position <= hit_ff ? pos_ff : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### rtl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Table of signed 32-bit values with single-entry loads and binary search.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload                                   Transfer
// req_*     in         mode, entry_index, item_value             valid & ready
// rsp_*     out        found, match_position                     valid & ready
// csr_*     in         entry_count (11 bits)                     valid & ready
//
// A load is written on its transfer. Each search probe is a registered table
// read in the check state and a compare in the compare state; at most 11 probes
// at 1024 entries. No new request is taken until the search's response loads.
// Reset clears the entry count, bounds and response valid; table contents are
// kept. A pending response does not block new requests; a finished search waits
// until the response register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire stbs_pkg::stbs_req_type       req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output stbs_pkg::stbs_rsp_type            rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [stbs_pkg::COUNT_W-1:0] csr_data
);
   import stbs_pkg::*;

   stbs_cmd_type cmd;
   stbs_sts_type sts;

   // Register is always writable
   assign csr_ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the binary search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire stbs_pkg::stbs_req_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire stbs_pkg::stbs_rsp_type rsp_data
);
   import stbs_pkg::*;

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_position == '0)
      else $error("miss with nonzero position");

   // A search transfer makes the core busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_SEARCH |=> !req_ready)
      else $error("request accepted during a search");

   // A new response only appears at the end of a search
   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a search");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### dv/tb_sorted_table_binary_search_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_core
// Self-checking bench for the sorted-table binary search core. Ascending base
// values are loaded along each search's probe path, then directed and random
// phases of loads and searches run under several entry counts, including
// empty, single, full and saturated.
// A built-in predictor follows every load and search and checks each response.
// ----------------------------------------------------------------------------

module tb_sorted_table_binary_search_core;
   import stbs_pkg::*;

   localparam int     TABLE_DEPTH   = 1024;
   localparam int     COUNT_MAX     = (1 << COUNT_W) - 1;
   localparam longint VALUE_MIN     = -64'sd2147483648;
   localparam longint VALUE_MAX     = 64'sd2147483647;
   localparam longint BASE_SPACING  = 64'sd4194304;
   localparam int     SETTLE_CYCLES = 30;
   localparam int     ITEM_BUDGET   = 450;
   localparam int     HOLD_AT       = 25;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     CYCLE_LIMIT   = 500000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   stbs_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   stbs_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_data  = '0;

   // Shadow of the block: table contents and the entry count in force
   logic signed [VALUE_W-1:0] table_values [0:TABLE_DEPTH-1];
   logic [COUNT_W-1:0]        entry_count_cfg = '0;

   // Table contents as queued, ahead of the transfers
   logic signed [VALUE_W-1:0] plan_values  [0:TABLE_DEPTH-1];
   bit                        plan_written [0:TABLE_DEPTH-1];

   stbs_req_type pending_reqs [$];
   stbs_rsp_type expected_rsps [$];

   int  queued_items    = 0;
   int  accepted_items  = 0;
   int  loads_done      = 0;
   int  searches_done   = 0;
   int  results_checked = 0;
   int  hits_seen       = 0;
   int  count_writes    = 0;
   int  mismatch_count  = 0;
   int  cycle_count     = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  quiet           = 1'b0;

   sorted_table_binary_search_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Binary search over the shadow table, same probe order as the block
   function automatic stbs_rsp_type predict_search(input logic signed [VALUE_W-1:0] target);
      stbs_rsp_type result;
      int           span, lower, upper, middle;
      bit           hit;
      result = '0;
      hit    = 1'b0;
      span   = (entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg);
      lower  = 0;
      upper  = span - 1;
      while (!hit && lower <= upper) begin
         middle = lower + (upper - lower) / 2;
         if (table_values[middle] == target) begin
            hit                   = 1'b1;
            result.found          = 1'b1;
            result.match_position = middle[INDEX_W-1:0];
         end else if (target < table_values[middle]) begin
            upper = middle - 1;
         end else begin
            lower = middle + 1;
         end
      end
      return result;
   endfunction

   // Evenly spaced ascending values spanning the full signed range
   function automatic logic [VALUE_W-1:0] base_value(input int pos);
      longint v;
      v = VALUE_MIN + longint'(pos) * BASE_SPACING;
      if (pos == TABLE_DEPTH - 1)
         v = VALUE_MAX;
      return v[VALUE_W-1:0];
   endfunction

   function automatic void queue_item(input logic mode, input int pos,
                                      input logic [VALUE_W-1:0] value);
      stbs_req_type it;
      it.mode        = mode;
      it.entry_index = pos[INDEX_W-1:0];
      it.item_value  = value;
      pending_reqs.push_back(it);
      queued_items++;
      if (mode == MODE_LOAD) begin
         plan_values[pos]  = value;
         plan_written[pos] = 1'b1;
      end
   endfunction

   // Search item, preceded by base loads for any entry its probes would find unwritten
   function automatic void queue_search(input int pos,
                                        input logic signed [VALUE_W-1:0] target);
      int lower, upper, middle;
      bit hit;
      hit   = 1'b0;
      lower = 0;
      upper = ((entry_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_cfg)) - 1;
      while (!hit && lower <= upper) begin
         middle = lower + (upper - lower) / 2;
         if (!plan_written[middle])
            queue_item(MODE_LOAD, middle, base_value(middle));
         if (plan_values[middle] == target)
            hit = 1'b1;
         else if (target < plan_values[middle])
            upper = middle - 1;
         else
            lower = middle + 1;
      end
      queue_item(MODE_SEARCH, pos, target);
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] ERROR %s", $realtime, msg);
   endfunction

   // Block is idle once every item is in and every response is out
   task automatic wait_drained();
      while (accepted_items != queued_items || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_entry_count(input logic [COUNT_W-1:0] count);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      entry_count_cfg = count;
      count_writes++;
   endtask

   // Request driver: tracks the shadow on each transfer, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_items++;
            if (req_data.mode == MODE_LOAD) begin
               table_values[req_data.entry_index] = req_data.item_value;
               loads_done++;
            end else begin
               expected_rsps.push_back(predict_search(req_data.item_value));
               searches_done++;
            end
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer, random stalls, one long hold-off
   always @(posedge clock) begin
      stbs_rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_rsps.size() == 0) begin
               flag_error($sformatf("unexpected response found=%0b position=%0d",
                                    rsp_data.found, rsp_data.match_position));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data.found !== exp_rsp.found)
                  flag_error($sformatf("found: expected %0b, got %0b",
                                       exp_rsp.found, rsp_data.found));
               if (rsp_data.match_position !== exp_rsp.match_position)
                  flag_error($sformatf("match_position: expected %0d, got %0d",
                                       exp_rsp.match_position, rsp_data.match_position));
               if (exp_rsp.found)
                  hits_seen++;
            end
         end
         // back-pressure long enough for the block to stall its input
         if (!hold_done && results_checked >= HOLD_AT && pending_reqs.size() > 4) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || $urandom_range(0, 99) >= 37;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      logic [COUNT_W-1:0] count;
      logic [VALUE_W-1:0] target;
      longint             v;
      int                 step_max, span, n_ops, r, pick, phase;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table straight out of reset
      queue_search(0, '0);
      queue_search(TABLE_DEPTH - 1, base_value(TABLE_DEPTH - 1));
      wait_drained();

      // full table: both ends, first probe, zero, misses in gaps
      write_entry_count(COUNT_W'(TABLE_DEPTH));
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(0));
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(TABLE_DEPTH - 1));
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(511));
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(512));
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(0) + 1);
      queue_search($urandom_range(0, TABLE_DEPTH - 1), base_value(1022) + 1);
      queue_search($urandom_range(0, TABLE_DEPTH - 1), '1);
      wait_drained();

      // count above the depth saturates
      write_entry_count(COUNT_W'(COUNT_MAX));
      queue_search(TABLE_DEPTH - 1, base_value(TABLE_DEPTH - 1));
      queue_search(0, base_value(700));
      wait_drained();

      // single entry: hit, miss above and far above
      write_entry_count(COUNT_W'(1));
      queue_search(0, base_value(0));
      queue_search(0, base_value(0) + 1);
      queue_search(0, base_value(TABLE_DEPTH - 1));
      // unsorted prefix: probes follow the order, a present value can be missed
      queue_item(MODE_LOAD, 0, 50);
      queue_item(MODE_LOAD, 1, 10);
      queue_item(MODE_LOAD, 2, 40);
      queue_item(MODE_LOAD, 3, 20);
      wait_drained();
      write_entry_count(COUNT_W'(4));
      queue_search(1, 10);
      queue_search(2, 20);
      queue_search(3, 40);
      queue_search(0, 50);
      wait_drained();

      // empty table once more
      write_entry_count(COUNT_W'(0));
      queue_search(2, 40);

      // random phases: new count, sorted prefix, then searches with some noise
      phase = 0;
      while (queued_items < ITEM_BUDGET || phase < 2) begin
         wait_drained();
         quiet = (phase == 1);
         r = $urandom_range(0, 99);
         if (r < 70)
            count = COUNT_W'($urandom_range(0, 40));
         else if (r < 90)
            count = COUNT_W'($urandom_range(41, TABLE_DEPTH));
         else
            count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, COUNT_MAX));
         write_entry_count(count);
         span = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

         if (span <= 40) begin
            case ($urandom_range(0, 3))
               0: step_max = 0;
               1: step_max = 3;
               2: step_max = 1000;
               default: step_max = 1 << 24;
            endcase
            if ($urandom_range(0, 6) == 0)
               v = VALUE_MIN;
            else
               v = longint'($signed($urandom)) - longint'(span) * step_max / 2;
            if (v < VALUE_MIN)
               v = VALUE_MIN;
            for (int k = 0; k < span; k++) begin
               queue_item(MODE_LOAD, k, v[VALUE_W-1:0]);
               v = v + $urandom_range(0, step_max);
               if (v > VALUE_MAX)
                  v = VALUE_MAX;
            end
         end else begin
            // restore the ascending base where small phases left their values
            for (int k = 0; k < 64; k++)
               queue_item(MODE_LOAD, k, base_value(k));
         end
         while (accepted_items != queued_items) @(negedge clock);

         n_ops = quiet ? 120 : $urandom_range(20, 50);
         for (int k = 0; k < n_ops; k++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
               // stray load: past the count it is harmless, inside it breaks the order
               queue_item(MODE_LOAD, $urandom_range(0, TABLE_DEPTH - 1), $urandom);
            end else begin
               target = $urandom;
               if (span != 0 && r < 80) begin
                  pick   = $urandom_range(0, span - 1);
                  target = plan_written[pick] ? plan_values[pick] : base_value(pick);
                  if (r >= 62)
                     target = (r[0]) ? target + 1 : target - 1;
               end
               queue_search($urandom_range(0, TABLE_DEPTH - 1), target);
            end
         end
         phase++;
      end
      wait_drained();
      quiet = 1'b0;

      if (expected_rsps.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_rsps.size()));

      $display("ran %0d searches (%0d hits) and %0d table loads over %0d entry_count settings",
               searches_done, hits_seen, loads_done, count_writes);
      $display("%0d responses checked, %0d errors, %0d cycles",
               results_checked, mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_dpath.sv
rtl/sorted_table_binary_search_core.sv
rtl/stbs_checker.sv
dv/tb_sorted_table_binary_search_core.sv
